FILE: hdl/pksd_pkg.sv
package pksd_pkg;

  localparam int KEYS_DEFAULT = 3;

  localparam int KEY_W    = 4;
  localparam int DIST_W   = 12;
  localparam int TIME_W   = 32;
  localparam int SEL_W    = 2;
  localparam int LEVEL_W  = 14;
  localparam int NOTE_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LET_OFF_RESET = 14'd2500;
  localparam logic [LEVEL_W-1:0] STRIKE_RESET  = 14'd2100;
  localparam logic [LEVEL_W-1:0] DROP_RESET    = 14'd3000;

  localparam logic [NOTE_W-1:0] BOARD_RESET    = 7'd0;
  localparam logic [NOTE_W-1:0] BASE_RESET     = 7'd65;
  localparam logic [NOTE_W-1:0] VELOCITY_RESET = 7'd80;
  localparam logic [NOTE_W-1:0] NOTE_MAX       = 7'd127;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_INDEX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_NOTE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_VELOCITY = 2'd2;

  localparam logic [SEL_W-1:0] THR_LET_OFF = 2'd0;
  localparam logic [SEL_W-1:0] THR_STRIKE  = 2'd1;
  localparam logic [SEL_W-1:0] THR_DROP    = 2'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_THRESH = 1'b1
  } op_e;

  typedef enum logic {
    EV_NOTE_ON  = 1'b0,
    EV_NOTE_OFF = 1'b1
  } event_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FLY   = 2'd1,
    PH_SOUND = 2'd2
  } phase_e;

  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [DIST_W-1:0]  sample;
    logic [TIME_W-1:0]  ts;
    logic [SEL_W-1:0]   sel;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic              fire;
    event_e            kind;
    logic [TIME_W-1:0] flight;
  } event_t;

endpackage

FILE: hdl/piano_key_strike_detector.sv
// Piano key strike detector: takes one item per clock (a hammer distance sample or a
// threshold write for one key) and reports note-on events with flight time and
// note-off events. An accepted item is held in the input register, is decided
// against its key's phase and thresholds, and its result, if any, is written into
// the result register as the item leaves, so the sustained rate is one item per
// cycle. The only thing that holds the input back is a result waiting in the result
// register while out_ready_i is low and the held item needs to advance.
// Configuration writes are always taken (cfg_ready_o is tied high).
module piano_key_strike_detector
  import pksd_pkg::*;
#(
  parameter int KEYS = KEYS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [KEY_W-1:0]     key_index_i,
  input  logic [DIST_W-1:0]    distance_sample_i,
  input  logic [TIME_W-1:0]    timestamp_ms_i,
  input  logic [SEL_W-1:0]     threshold_select_i,
  input  logic [LEVEL_W-1:0]   threshold_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 event_kind_o,
  output logic [NOTE_W-1:0]    note_number_o,
  output logic [NOTE_W-1:0]    velocity_o,
  output logic [TIME_W-1:0]    flight_time_ms_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [NOTE_W-1:0]    cfg_data_i
);

  localparam int SumW = $clog2(128 * (KEYS + 1) + KEYS);

  logic [NOTE_W-1:0] board_q;
  logic [NOTE_W-1:0] base_q;
  logic [NOTE_W-1:0] vel_cfg_q;

  logic  s1_valid_q;
  item_t s1_q;
  logic  s1_adv;

  event_t ev;

  logic              out_valid_q;
  event_e            kind_q;
  logic [NOTE_W-1:0] note_q;
  logic [NOTE_W-1:0] vel_q;
  logic [TIME_W-1:0] flight_q;

  logic [SumW-1:0]   note_sum;
  logic [NOTE_W-1:0] note_sat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q   <= BOARD_RESET;
      base_q    <= BASE_RESET;
      vel_cfg_q <= VELOCITY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BOARD_INDEX:    board_q   <= cfg_data_i;
        CFG_BASE_NOTE:      base_q    <= cfg_data_i;
        CFG_FIXED_VELOCITY: vel_cfg_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // advance the held item only when the result register can take its result
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q.op     <= op_e'(operation_i);
      s1_q.key    <= key_index_i;
      s1_q.sample <= distance_sample_i;
      s1_q.ts     <= timestamp_ms_i;
      s1_q.sel    <= threshold_select_i;
      s1_q.level  <= threshold_value_i;
    end
  end

  pksd_key_bank #(
    .KEYS(KEYS)
  ) u_key_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_q),
    .event_o(ev)
  );

  assign note_sum = SumW'(base_q) + SumW'(s1_q.key) + SumW'(board_q) * SumW'(KEYS);
  assign note_sat = (note_sum > SumW'(NOTE_MAX)) ? NOTE_MAX : note_sum[NOTE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= ev.fire;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && ev.fire) begin
      kind_q   <= ev.kind;
      note_q   <= note_sat;
      vel_q    <= (ev.kind == EV_NOTE_ON) ? vel_cfg_q : '0;
      flight_q <= ev.flight;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign note_number_o    = note_q;
  assign velocity_o       = vel_q;
  assign flight_time_ms_o = flight_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("held item changed or was lost");

  a_note_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == EV_NOTE_OFF) |-> (vel_q == '0 && flight_q == '0))
    else $error("note-off carries velocity or flight time");

endmodule

FILE: hdl/pksd_key_bank.sv
module pksd_key_bank
  import pksd_pkg::*;
#(
  parameter int KEYS = KEYS_DEFAULT
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  item_t  item_i,
  output event_t event_o
);

  localparam int KeyIdxW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [KEY_W:0] KeysLimit = (KEY_W+1)'(KEYS);

  phase_e             phase_q  [KEYS];
  logic [TIME_W-1:0]  start_q  [KEYS];
  logic [LEVEL_W-1:0] let_off_q[KEYS];
  logic [LEVEL_W-1:0] strike_q [KEYS];
  logic [LEVEL_W-1:0] drop_q   [KEYS];

  logic [KeyIdxW-1:0] idx;
  logic               in_range;
  phase_e             phase_rd;
  phase_e             phase_d;
  logic               phase_we;
  logic               start_we;
  logic               let_off_we;
  logic               strike_we;
  logic               drop_we;
  logic [LEVEL_W-1:0] dist_ext;

  assign idx      = item_i.key[KeyIdxW-1:0];
  assign in_range = {1'b0, item_i.key} < KeysLimit;
  assign phase_rd = phase_q[idx];
  assign dist_ext = {{(LEVEL_W-DIST_W){1'b0}}, item_i.sample};

  always_comb begin
    event_o    = '0;
    phase_d    = phase_rd;
    phase_we   = 1'b0;
    start_we   = 1'b0;
    let_off_we = 1'b0;
    strike_we  = 1'b0;
    drop_we    = 1'b0;
    if (step_i && in_range) begin
      if (item_i.op == OP_THRESH) begin
        case (item_i.sel)
          THR_LET_OFF: let_off_we = 1'b1;
          THR_STRIKE:  strike_we  = 1'b1;
          THR_DROP:    drop_we    = 1'b1;
          default:     ;
        endcase
      end else begin
        case (phase_rd)
          PH_FLY: begin
            if (dist_ext < strike_q[idx]) begin
              phase_d        = PH_SOUND;
              phase_we       = 1'b1;
              event_o.fire   = 1'b1;
              event_o.kind   = EV_NOTE_ON;
              event_o.flight = item_i.ts - start_q[idx];
            end else if (dist_ext > let_off_q[idx]) begin
              phase_d  = PH_IDLE;
              phase_we = 1'b1;
            end
          end
          PH_SOUND: begin
            if (dist_ext > drop_q[idx]) begin
              phase_d      = PH_IDLE;
              phase_we     = 1'b1;
              event_o.fire = 1'b1;
              event_o.kind = EV_NOTE_OFF;
            end
          end
          default: begin
            // an unused code behaves as idle and is normalised here
            phase_we = 1'b1;
            if (dist_ext < let_off_q[idx]) begin
              phase_d  = PH_FLY;
              start_we = 1'b1;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEYS; k++) begin
        phase_q[k]   <= PH_IDLE;
        start_q[k]   <= '0;
        let_off_q[k] <= LET_OFF_RESET;
        strike_q[k]  <= STRIKE_RESET;
        drop_q[k]    <= DROP_RESET;
      end
    end else begin
      if (phase_we)   phase_q[idx]   <= phase_d;
      if (start_we)   start_q[idx]   <= item_i.ts;
      if (let_off_we) let_off_q[idx] <= item_i.level;
      if (strike_we)  strike_q[idx]  <= item_i.level;
      if (drop_we)    drop_q[idx]    <= item_i.level;
    end
  end

endmodule
